FILE: rtl/core/cnp_pkg.sv
`timescale 1ns / 1ps
// Package for the clamped neighbour product block: beat payload types,
// operation and register codes. Depends on nothing.
package cnp_pkg;

  localparam int SampleBits  = 16;
  localparam int ProductBits = 2 * SampleBits;
  localparam int CoordBits   = 6;
  localparam int CfgBits     = 7;
  localparam int PaddrBits   = 4;

  typedef enum logic {
    OP_WRITE   = 1'b0,
    OP_COMPUTE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    REG_PLANE_WIDTH  = 2'd0,
    REG_PLANE_HEIGHT = 2'd1,
    REG_ROW_OFFSET   = 2'd2,
    REG_COL_OFFSET   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic                         operation;
    logic [CoordBits-1:0]         row;
    logic [CoordBits-1:0]         col;
    logic signed [SampleBits-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic signed [ProductBits-1:0] product;
    logic                          out_of_range;
  } out_item_t;

endpackage

FILE: rtl/core/clamped_neighbor_product.sv
`timescale 1ns / 1ps
// Clamped neighbour product: plane store, partner address clamp and
// multiplier, with an APB register file. Depends on cnp_pkg.
// A compute beat's result passes the plane store read registers, then the output register.
// Throughput: one beat per cycle while the output is not stalled, set by the two read ports
// and one write port of the plane store; a write beat gives no result.
// Reset clears the registers to their defaults and the pipeline valids;
// the plane store is not cleared and holds no meaning until written.
module clamped_neighbor_product #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [cnp_pkg::PaddrBits-1:0]      paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  cnp_pkg::in_item_t                  in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output cnp_pkg::out_item_t                 out_item_o
);
  import cnp_pkg::*;

  localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(Depth);
  localparam int WBits = $clog2(MAX_WIDTH + 1);
  localparam int HBits = $clog2(MAX_HEIGHT + 1);
  localparam int MBits = (WBits > HBits) ? WBits : HBits;
  localparam int CW    = (MBits > CfgBits) ? MBits : CfgBits;
  localparam int SW    = CW + 1;

  logic [CfgBits-1:0]        plane_width_q, plane_height_q;
  logic signed [CfgBits-1:0] row_offset_q, col_offset_q;
  logic                      cfg_write;
  cfg_reg_e                  cfg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign cfg_sel   = cfg_reg_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_width_q  <= CfgBits'(64);
      plane_height_q <= CfgBits'(64);
      row_offset_q   <= -CfgBits'(1);
      col_offset_q   <= -CfgBits'(1);
    end else if (cfg_write) begin
      case (cfg_sel)
        REG_PLANE_WIDTH:  plane_width_q  <= pwdata[CfgBits-1:0];
        REG_PLANE_HEIGHT: plane_height_q <= pwdata[CfgBits-1:0];
        REG_ROW_OFFSET:   row_offset_q   <= pwdata[CfgBits-1:0];
        REG_COL_OFFSET:   col_offset_q   <= pwdata[CfgBits-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      REG_PLANE_WIDTH:  prdata = 32'(plane_width_q);
      REG_PLANE_HEIGHT: prdata = 32'(plane_height_q);
      REG_ROW_OFFSET:   prdata = 32'(unsigned'(row_offset_q));
      REG_COL_OFFSET:   prdata = 32'(unsigned'(col_offset_q));
      default:          prdata = 32'd0;
    endcase
  end

  logic [CW-1:0] w_eff, h_eff;

  always_comb begin
    if (plane_width_q == '0) begin
      w_eff = CW'(1);
    end else if (CW'(plane_width_q) > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(plane_width_q);
    end
    if (plane_height_q == '0) begin
      h_eff = CW'(1);
    end else if (CW'(plane_height_q) > CW'(MAX_HEIGHT)) begin
      h_eff = CW'(MAX_HEIGHT);
    end else begin
      h_eff = CW'(plane_height_q);
    end
  end

  logic                 s1_valid_q, s1_oor_q;
  logic                 out_valid_q;
  out_item_t            out_item_q;
  logic                 out_free, s1_free, accept;
  logic                 pos_in_plane, is_compute;
  logic signed [SW-1:0] row_sum, col_sum;
  logic [CW-1:0]        part_row, part_col;
  logic [AW-1:0]        own_addr, part_addr;

  assign out_free     = !out_valid_q || !out_stall_i;
  assign s1_free      = !s1_valid_q || out_free;
  assign in_stall_o   = !s1_free;
  assign accept       = in_valid_i && s1_free;
  assign is_compute   = (in_item_i.operation == OP_COMPUTE);
  assign pos_in_plane = (CW'(in_item_i.row) < h_eff) && (CW'(in_item_i.col) < w_eff);

  assign row_sum = $signed(SW'(in_item_i.row)) + SW'(row_offset_q);
  assign col_sum = $signed(SW'(in_item_i.col)) + SW'(col_offset_q);

  always_comb begin
    if (row_sum < 0) begin
      part_row = '0;
    end else if (row_sum > $signed(SW'(h_eff - CW'(1)))) begin
      part_row = h_eff - CW'(1);
    end else begin
      part_row = row_sum[CW-1:0];
    end
    if (col_sum < 0) begin
      part_col = '0;
    end else if (col_sum > $signed(SW'(w_eff - CW'(1)))) begin
      part_col = w_eff - CW'(1);
    end else begin
      part_col = col_sum[CW-1:0];
    end
  end

  assign own_addr  = AW'(in_item_i.row) * AW'(MAX_WIDTH) + AW'(in_item_i.col);
  assign part_addr = AW'(part_row) * AW'(MAX_WIDTH) + AW'(part_col);

  logic signed [SampleBits-1:0] plane_mem [Depth];
  logic signed [SampleBits-1:0] own_rd_q, part_rd_q;
  logic signed [ProductBits-1:0] s1_product;

  always_ff @(posedge clk_i) begin
    if (accept && !is_compute && pos_in_plane) begin
      plane_mem[own_addr] <= in_item_i.sample;
    end
    if (accept && is_compute && pos_in_plane) begin
      own_rd_q  <= plane_mem[own_addr];
      part_rd_q <= plane_mem[part_addr];
    end
  end

  assign s1_product = own_rd_q * part_rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid_q <= accept && is_compute;
      end
      if (out_free) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_compute) begin
      s1_oor_q <= !pos_in_plane;
    end
    if (out_free && s1_valid_q) begin
      out_item_q.out_of_range <= s1_oor_q;
      out_item_q.product      <= s1_oor_q ? '0 : s1_product;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for clamped_neighbor_product: it drives write and compute beats through
// the item channel and predicts every product beside it. Depends on cnp_pkg and the block.
module tb_top;
  import cnp_pkg::*;

  localparam int MaxWidth   = 64;
  localparam int MaxHeight  = 64;
  localparam int PlaneCells = MaxWidth * MaxHeight;

  class product_checker;
    logic signed [SampleBits-1:0] plane [PlaneCells];
    bit                           written [PlaneCells];
    logic [CfgBits-1:0]           width_q;
    logic [CfgBits-1:0]           height_q;
    logic signed [CfgBits-1:0]    row_off_q;
    logic signed [CfgBits-1:0]    col_off_q;
    out_item_t                    pending_products [$];
    int                           errors;

    function new();
      width_q   = 7'd64;
      height_q  = 7'd64;
      row_off_q = -7'sd1;
      col_off_q = -7'sd1;
      errors    = 0;
    endfunction

    function int used_width();
      if (width_q == 0) return 1;
      if (width_q > MaxWidth) return MaxWidth;
      return int'(width_q);
    endfunction

    function int used_height();
      if (height_q == 0) return 1;
      if (height_q > MaxHeight) return MaxHeight;
      return int'(height_q);
    endfunction

    function bit in_plane(int r, int c);
      return (r < used_height()) && (c < used_width());
    endfunction

    function int partner_cell(int r, int c);
      int pr, pc;
      pr = r + int'(row_off_q);
      pc = c + int'(col_off_q);
      if (pr < 0) pr = 0;
      if (pr > used_height() - 1) pr = used_height() - 1;
      if (pc < 0) pc = 0;
      if (pc > used_width() - 1) pc = used_width() - 1;
      return pr * MaxWidth + pc;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [31:0] data);
      case (idx)
        REG_PLANE_WIDTH:  width_q   = data[CfgBits-1:0];
        REG_PLANE_HEIGHT: height_q  = data[CfgBits-1:0];
        REG_ROW_OFFSET:   row_off_q = data[CfgBits-1:0];
        REG_COL_OFFSET:   col_off_q = data[CfgBits-1:0];
        default: ;
      endcase
    endfunction

    function void apply_beat(in_item_t beat);
      out_item_t want;
      int        r, c, own, mate;
      r   = int'(beat.row);
      c   = int'(beat.col);
      own = r * MaxWidth + c;
      if (beat.operation == OP_WRITE) begin
        if (in_plane(r, c)) begin
          plane[own]   = beat.sample;
          written[own] = 1'b1;
        end
        return;
      end
      if (!in_plane(r, c)) begin
        want.product      = '0;
        want.out_of_range = 1'b1;
      end else begin
        mate              = partner_cell(r, c);
        want.product      = ProductBits'(int'(plane[own]) * int'(plane[mate]));
        want.out_of_range = 1'b0;
      end
      pending_products.push_back(want);
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (pending_products.size() == 0) begin
        report_mismatch($sformatf("unexpected result, product %0d flag %0b",
                                  got.product, got.out_of_range));
        return;
      end
      want = pending_products.pop_front();
      if (got.product !== want.product)
        report_mismatch($sformatf("product %0d, expected %0d", got.product, want.product));
      if (got.out_of_range !== want.out_of_range)
        report_mismatch($sformatf("out_of_range %0b, expected %0b",
                                  got.out_of_range, want.out_of_range));
    endtask
  endclass

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  psel        = 1'b0;
  logic                  penable     = 1'b0;
  logic                  pwrite      = 1'b0;
  logic [PaddrBits-1:0]  paddr       = '0;
  logic [31:0]           pwdata      = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  in_item_t              in_item_i   = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  out_item_t             out_item_o;

  product_checker        checker_h;
  int                    send_gap_pct = 0;
  int                    stall_pct    = 0;

  clamped_neighbor_product #(
    .MAX_WIDTH (MaxWidth),
    .MAX_HEIGHT(MaxHeight)
  ) u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) checker_h.check_result(out_item_o);
  end

  function automatic in_item_t make_beat(op_e op, int r, int c, logic [SampleBits-1:0] s);
    in_item_t b;
    b.operation = op;
    b.row       = CoordBits'(r);
    b.col       = CoordBits'(c);
    b.sample    = s;
    return b;
  endfunction

  function automatic logic [CfgBits-1:0] random_size();
    if ($urandom_range(3) == 0) return CfgBits'($urandom);
    return CfgBits'($urandom_range(1, 12));
  endfunction

  task automatic send_beat(in_item_t beat);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
    checker_h.apply_beat(beat);
  endtask

  // A compute inside the plane only reads cells that hold a sample, so any missing one is
  // written first with a random value.
  task automatic compute_at(int r, int c);
    int own, mate;
    if (checker_h.in_plane(r, c)) begin
      own = r * MaxWidth + c;
      if (!checker_h.written[own])
        send_beat(make_beat(OP_WRITE, r, c, SampleBits'($urandom)));
      mate = checker_h.partner_cell(r, c);
      if (!checker_h.written[mate])
        send_beat(make_beat(OP_WRITE, mate / MaxWidth, mate % MaxWidth, SampleBits'($urandom)));
    end
    send_beat(make_beat(OP_COMPUTE, r, c, SampleBits'($urandom)));
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (checker_h.pending_products.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CfgBits-1:0] value);
    logic [31:0] data;
    data = {25'($urandom), value};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    checker_h.set_reg(idx, data);
    @(posedge clk_i);
  endtask

  task automatic configure(logic [CfgBits-1:0] w, logic [CfgBits-1:0] h,
                           logic [CfgBits-1:0] ro, logic [CfgBits-1:0] co);
    settle();
    write_reg(REG_PLANE_WIDTH, w);
    write_reg(REG_PLANE_HEIGHT, h);
    write_reg(REG_ROW_OFFSET, ro);
    write_reg(REG_COL_OFFSET, co);
  endtask

  task automatic run_random(int count);
    int pick, r, c;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) settle();
      pick = $urandom_range(99);
      if (pick < 80) begin
        r = $urandom_range(checker_h.used_height() - 1);
        c = $urandom_range(checker_h.used_width() - 1);
        if (pick < 50) compute_at(r, c);
        else send_beat(make_beat(OP_WRITE, r, c, SampleBits'($urandom)));
      end else begin
        r = $urandom_range(MaxHeight - 1);
        c = $urandom_range(MaxWidth - 1);
        if ($urandom_range(1) == 1) compute_at(r, c);
        else send_beat(make_beat(OP_WRITE, r, c, SampleBits'($urandom)));
      end
    end
  endtask

  initial begin
    #1_000_000;
    $display("clamped_neighbor_product verification failed");
    $finish;
  end

  initial begin
    checker_h = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: full plane, partner one up and one to the left.
    send_beat(make_beat(OP_WRITE, 0, 0, 16'sh8000));
    compute_at(0, 0);
    send_beat(make_beat(OP_WRITE, 62, 62, 16'sh8000));
    send_beat(make_beat(OP_WRITE, 63, 63, 16'sh7fff));
    compute_at(63, 63);
    send_beat(make_beat(OP_WRITE, 0, 63, 16'sh0000));
    send_beat(make_beat(OP_WRITE, 0, 62, 16'sh7fff));
    compute_at(0, 63);
    send_beat(make_beat(OP_WRITE, 1, 1, 16'sh7fff));
    compute_at(1, 1);

    // Small plane: positions outside it are flagged or ignored.
    configure(7'd3, 7'd2, 7'd1, 7'h7e);
    compute_at(5, 1);
    compute_at(0, 40);
    send_beat(make_beat(OP_WRITE, 63, 63, 16'sh1234));
    compute_at(1, 2);
    compute_at(63, 63);

    // Zero sizes act as one, extreme offsets clamp to the single cell.
    configure(7'd0, 7'd0, 7'h3f, 7'h40);
    compute_at(0, 0);
    compute_at(0, 1);
    send_beat(make_beat(OP_WRITE, 0, 1, 16'sh0101));

    // Oversized plane acts as the full store; the ignored write left its cell alone.
    configure(7'd127, 7'd100, 7'h40, 7'h3f);
    compute_at(63, 0);
    compute_at(63, 63);

    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0:       configure(7'd64, 7'd64, 7'd0, 7'd0);
        1:       configure(7'd1, 7'd64, 7'd5, 7'h7f);
        2:       configure(7'd64, 7'd1, 7'h7d, 7'd7);
        3:       configure(7'd127, 7'd0, 7'h3f, 7'h40);
        4:       configure(7'd8, 7'd8, 7'h7f, 7'd1);
        default: configure(random_size(), random_size(), CfgBits'($urandom), CfgBits'($urandom));
      endcase
      case (ph % 4)
        0: begin
          send_gap_pct = 0;
          stall_pct    = 0;
        end
        1: begin
          send_gap_pct = 47;
          stall_pct    = 0;
        end
        2: begin
          send_gap_pct = 0;
          stall_pct    = 47;
        end
        default: begin
          send_gap_pct = 19;
          stall_pct    = 19;
        end
      endcase
      run_random(125);
    end

    settle();
    repeat (6) @(posedge clk_i);
    if (checker_h.errors == 0 && checker_h.pending_products.size() == 0) begin
      $display("clamped_neighbor_product verification clean");
    end else begin
      $display("clamped_neighbor_product verification failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/cnp_pkg.sv
rtl/core/clamped_neighbor_product.sv
test/tb_top.sv
